/* design/rfb_client_message_parser_top_macros.svh */
// Assertion helpers for the RFB client parser
`ifndef RFB_CLIENT_MESSAGE_PARSER_TOP_MACROS_SVH
`define RFB_CLIENT_MESSAGE_PARSER_TOP_MACROS_SVH

`define RFB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfb check failed");

`define RFB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfb check failed");

`endif

/* design/rfb_pkg.sv */
`timescale 1ns / 1ps
package rfb_pkg;
	localparam int unsigned MaxEncodings = 64;
	localparam int unsigned MaxFrameSide = 4096;
	localparam logic [12:0] FrameWidthReset = 13'd1024;
	localparam logic [12:0] FrameHeightReset = 13'd768;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [3:0] {
		PH_VERSION, PH_SECURITY, PH_SHARED, PH_TYPE, PH_PIXFMT,
		PH_ENC_HEAD, PH_ENC_BODY, PH_UPDATE, PH_KEY, PH_POINTER
	} phase_t;

	typedef enum logic [3:0] {
		EV_VERSION = 4'd0, EV_SECURITY = 4'd1, EV_INIT = 4'd2, EV_PIXFMT = 4'd3,
		EV_ENCODINGS = 4'd4, EV_UPDATE = 4'd5, EV_KEY = 4'd6, EV_POINTER = 4'd7,
		EV_ERROR = 4'd8
	} event_t;

	localparam logic [0:0] CFG_FRAME_WIDTH = 1'b0;
	localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

	// classified message handed from front to back
	typedef struct packed {
		event_t      kind;
		logic [9:0]  minor;
		logic        flag;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
	} cmd_t;
endpackage

/* design/rfb_front.sv */
`timescale 1ns / 1ps
module rfb_front #(
	parameter int unsigned MAX_ENCODINGS = rfb_pkg::MaxEncodings
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      rx_byte,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output rfb_pkg::cmd_t   cmd
);
	rfb_pkg::phase_t phase_q, phase_d;
	logic [4:0]  pos_q, pos_d;
	logic [9:0]  minor_q, minor_d;
	logic [15:0] enc_q, enc_d;
	logic        err_q, err_d;
	logic        hdr_ok_q, hdr_ok_d;
	logic [7:0]  buf_q [0:15];
	logic        emit;
	rfb_pkg::cmd_t cmd_d;
	logic        take;
	logic        dig;
	logic [15:0] cnt;
	logic [3:0]  wr_idx;
	logic        wr_en;
	logic [7:0]  pfx;
	logic [3:0]  pf;

	assign in_ready = !cmd_valid || cmd_ready;
	assign take = in_valid && in_ready;
	assign dig = rx_byte >= 8'h30 && rx_byte <= 8'h39;
	assign cnt = {buf_q[1], rx_byte};
	assign pf = pos_q[3:0] - 4'd3;

	always_comb begin
		unique case (pos_q[2:0])
			3'd0: pfx = 8'h52;
			3'd1: pfx = 8'h46;
			3'd2: pfx = 8'h42;
			3'd3: pfx = 8'h20;
			3'd4: pfx = 8'h30;
			3'd5: pfx = 8'h30;
			3'd6: pfx = 8'h33;
			default: pfx = 8'h2e;
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		minor_d = minor_q;
		enc_d = enc_q;
		err_d = err_q;
		hdr_ok_d = hdr_ok_q;
		emit = 1'b0;
		wr_en = 1'b0;
		wr_idx = pos_q[3:0];
		cmd_d = '0;
		if (!err_q) begin
			unique case (phase_q)
				rfb_pkg::PH_VERSION: begin
					wr_en = 1'b1;
					if (pos_q < 5'd8 && rx_byte != pfx) hdr_ok_d = 1'b0;
					if (pos_q >= 5'd8 && pos_q <= 5'd10) begin
						if (!dig) hdr_ok_d = 1'b0;
						minor_d = 10'(minor_q * 10'd10 + (dig ? 10'(rx_byte - 8'h30) : 10'd0));
					end
					if (pos_q < 5'd11) pos_d = pos_q + 5'd1;
					else begin
						emit = 1'b1;
						if (!hdr_ok_q || rx_byte != 8'h0a ||
								!(minor_q == 10'd3 || minor_q == 10'd7 || minor_q == 10'd8)) begin
							err_d = 1'b1;
							cmd_d.kind = rfb_pkg::EV_ERROR;
						end else begin
							pos_d = '0;
							phase_d = (minor_q == 10'd3) ? rfb_pkg::PH_SHARED
								: rfb_pkg::PH_SECURITY;
							cmd_d.kind = rfb_pkg::EV_VERSION;
							cmd_d.minor = minor_q;
						end
					end
				end
				rfb_pkg::PH_SECURITY: begin
					emit = 1'b1;
					if (rx_byte != 8'd1) begin
						err_d = 1'b1;
						cmd_d.kind = rfb_pkg::EV_ERROR;
					end else begin
						phase_d = rfb_pkg::PH_SHARED;
						cmd_d.kind = rfb_pkg::EV_SECURITY;
					end
				end
				rfb_pkg::PH_SHARED: begin
					emit = 1'b1;
					cmd_d.kind = rfb_pkg::EV_INIT;
					phase_d = rfb_pkg::PH_TYPE;
					pos_d = '0;
				end
				rfb_pkg::PH_TYPE: begin
					pos_d = '0;
					hdr_ok_d = 1'b1;
					unique case (rx_byte)
						8'd0: phase_d = rfb_pkg::PH_PIXFMT;
						8'd2: phase_d = rfb_pkg::PH_ENC_HEAD;
						8'd3: phase_d = rfb_pkg::PH_UPDATE;
						8'd4: phase_d = rfb_pkg::PH_KEY;
						8'd5: phase_d = rfb_pkg::PH_POINTER;
						default: begin
							emit = 1'b1;
							err_d = 1'b1;
							cmd_d.kind = rfb_pkg::EV_ERROR;
						end
					endcase
				end
				rfb_pkg::PH_PIXFMT: begin
					// running check of each non-padding format byte as it arrives
					if (pos_q >= 5'd3 && pos_q <= 5'd15) begin
						unique case (pf)
							4'd0: if (rx_byte != 8'd32) hdr_ok_d = 1'b0;
							4'd1: if (rx_byte != 8'd24) hdr_ok_d = 1'b0;
							4'd2: if (rx_byte != 8'd0) hdr_ok_d = 1'b0;
							4'd3: if (rx_byte != 8'd1) hdr_ok_d = 1'b0;
							4'd4, 4'd6, 4'd8: if (rx_byte != 8'd0) hdr_ok_d = 1'b0;
							4'd5, 4'd7, 4'd9: if (rx_byte != 8'd255) hdr_ok_d = 1'b0;
							4'd10: if (rx_byte != 8'd16) hdr_ok_d = 1'b0;
							4'd11: if (rx_byte != 8'd8) hdr_ok_d = 1'b0;
							4'd12: if (rx_byte != 8'd0) hdr_ok_d = 1'b0;
							default: ;
						endcase
					end
					if (pos_q < 5'd18) pos_d = pos_q + 5'd1;
					else begin
						emit = 1'b1;
						if (!hdr_ok_q) begin
							err_d = 1'b1;
							cmd_d.kind = rfb_pkg::EV_ERROR;
						end else begin
							cmd_d.kind = rfb_pkg::EV_PIXFMT;
							phase_d = rfb_pkg::PH_TYPE;
							pos_d = '0;
						end
					end
				end
				rfb_pkg::PH_ENC_HEAD: begin
					wr_en = 1'b1;
					if (pos_q < 5'd2) pos_d = pos_q + 5'd1;
					else begin
						enc_d = cnt;
						pos_d = '0;
						if (32'(cnt) > MAX_ENCODINGS) begin
							emit = 1'b1;
							err_d = 1'b1;
							cmd_d.kind = rfb_pkg::EV_ERROR;
						end else if (cnt == 16'd0) begin
							emit = 1'b1;
							cmd_d.kind = rfb_pkg::EV_ENCODINGS;
							phase_d = rfb_pkg::PH_TYPE;
						end else phase_d = rfb_pkg::PH_ENC_BODY;
					end
				end
				rfb_pkg::PH_ENC_BODY: begin
					if (pos_q < 5'd3) pos_d = pos_q + 5'd1;
					else begin
						pos_d = '0;
						enc_d = enc_q - 16'd1;
						if (enc_q == 16'd1) begin
							emit = 1'b1;
							cmd_d.kind = rfb_pkg::EV_ENCODINGS;
							phase_d = rfb_pkg::PH_TYPE;
						end
					end
				end
				rfb_pkg::PH_UPDATE: begin
					wr_en = 1'b1;
					if (pos_q < 5'd8) pos_d = pos_q + 5'd1;
					else begin
						emit = 1'b1;
						cmd_d.kind = rfb_pkg::EV_UPDATE;
						cmd_d.flag = buf_q[0] != 8'd0;
						cmd_d.a = {buf_q[1], buf_q[2]};
						cmd_d.b = {buf_q[3], buf_q[4]};
						cmd_d.c = {buf_q[5], buf_q[6]};
						cmd_d.d = {buf_q[7], rx_byte};
						phase_d = rfb_pkg::PH_TYPE;
						pos_d = '0;
					end
				end
				rfb_pkg::PH_KEY: begin
					wr_en = 1'b1;
					if (pos_q < 5'd6) pos_d = pos_q + 5'd1;
					else begin
						emit = 1'b1;
						cmd_d.kind = rfb_pkg::EV_KEY;
						cmd_d.flag = buf_q[0] != 8'd0;
						cmd_d.a = {buf_q[3], buf_q[4]};
						cmd_d.b = {buf_q[5], rx_byte};
						phase_d = rfb_pkg::PH_TYPE;
						pos_d = '0;
					end
				end
				rfb_pkg::PH_POINTER: begin
					wr_en = 1'b1;
					if (pos_q < 5'd4) pos_d = pos_q + 5'd1;
					else begin
						emit = 1'b1;
						cmd_d.kind = rfb_pkg::EV_POINTER;
						cmd_d.a = {8'd0, buf_q[0]};
						cmd_d.b = {buf_q[1], buf_q[2]};
						cmd_d.c = {buf_q[3], rx_byte};
						phase_d = rfb_pkg::PH_TYPE;
						pos_d = '0;
					end
				end
				default: begin
					emit = 1'b1;
					err_d = 1'b1;
					cmd_d.kind = rfb_pkg::EV_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rfb_pkg::PH_VERSION;
			pos_q <= '0;
			minor_q <= '0;
			enc_q <= '0;
			err_q <= 1'b0;
			hdr_ok_q <= 1'b1;
			cmd_valid <= 1'b0;
		end else begin
			if (take && emit) cmd_valid <= 1'b1;
			else if (cmd_ready) cmd_valid <= 1'b0;
			if (take) begin
				phase_q <= phase_d;
				pos_q <= pos_d;
				minor_q <= minor_d;
				enc_q <= enc_d;
				err_q <= err_d;
				hdr_ok_q <= hdr_ok_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) cmd <= cmd_d;
		if (take && wr_en) buf_q[wr_idx] <= rx_byte;
	end
endmodule

/* design/rfb_queue.sv */
`timescale 1ns / 1ps
module rfb_queue #(
	parameter int unsigned DEPTH = rfb_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  rfb_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output rfb_pkg::cmd_t rd_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	rfb_pkg::cmd_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

/* design/rfb_back.sv */
`timescale 1ns / 1ps
module rfb_back #(
	parameter int unsigned MAX_FRAME_SIDE = rfb_pkg::MaxFrameSide
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rfb_pkg::cmd_t cmd,
	input  logic [12:0]   frame_width,
	input  logic [12:0]   frame_height,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    event_kind,
	output logic [9:0]    minor_version,
	output logic          incremental,
	output logic [15:0]   rect_x,
	output logic [15:0]   rect_y,
	output logic [12:0]   rect_width,
	output logic [12:0]   rect_height,
	output logic          key_down,
	output logic [31:0]   key_symbol,
	output logic [7:0]    button_mask,
	output logic [15:0]   pointer_x,
	output logic [15:0]   pointer_y
);
	logic [16:0] fw, fh, rw, rh, w, h;
	logic take, is_upd;

	assign cmd_ready = !out_valid || out_ready;
	assign take = cmd_valid && cmd_ready;
	assign is_upd = cmd.kind == rfb_pkg::EV_UPDATE;
	assign fw = (17'(frame_width) > 17'(MAX_FRAME_SIDE)) ? 17'(MAX_FRAME_SIDE)
		: 17'(frame_width);
	assign fh = (17'(frame_height) > 17'(MAX_FRAME_SIDE)) ? 17'(MAX_FRAME_SIDE)
		: 17'(frame_height);
	assign rw = fw - 17'(cmd.a);
	assign rh = fh - 17'(cmd.b);

	// clip to frame; outside origin gives empty rectangle
	always_comb begin
		if (17'(cmd.a) >= fw || 17'(cmd.b) >= fh) begin
			w = '0;
			h = '0;
		end else begin
			w = (17'(cmd.c) > rw) ? rw : 17'(cmd.c);
			h = (17'(cmd.d) > rh) ? rh : 17'(cmd.d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (take) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			event_kind <= cmd.kind;
			minor_version <= cmd.minor;
			incremental <= is_upd && cmd.flag;
			rect_x <= is_upd ? cmd.a : '0;
			rect_y <= is_upd ? cmd.b : '0;
			rect_width <= is_upd ? w[12:0] : '0;
			rect_height <= is_upd ? h[12:0] : '0;
			key_down <= (cmd.kind == rfb_pkg::EV_KEY) && cmd.flag;
			key_symbol <= (cmd.kind == rfb_pkg::EV_KEY) ? {cmd.a, cmd.b} : '0;
			button_mask <= (cmd.kind == rfb_pkg::EV_POINTER) ? cmd.a[7:0] : '0;
			pointer_x <= (cmd.kind == rfb_pkg::EV_POINTER) ? cmd.b : '0;
			pointer_y <= (cmd.kind == rfb_pkg::EV_POINTER) ? cmd.c : '0;
		end
	end
endmodule

/* design/rfb_client_message_parser_top.sv */
`timescale 1ns / 1ps
// channel   handshake               payload
// in        in_valid / in_ready     rx_byte
// out       out_valid / out_ready   event_kind .. pointer_y
// cfg       cfg_we                  cfg_index, cfg_data
// One byte per cycle when the output side keeps up; events see two register
// stages (front classify, back clip) plus a two-entry request queue.
// The front stalls only when its output register holds a request the queue
// cannot take. Reset clears phase, counters and the error latch.
// After an error no further request is produced until reset.
module rfb_client_message_parser_top #(
	parameter int unsigned MAX_ENCODINGS = rfb_pkg::MaxEncodings,
	parameter int unsigned MAX_FRAME_SIDE = rfb_pkg::MaxFrameSide
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_kind,
	output logic [9:0]  minor_version,
	output logic        incremental,
	output logic [15:0] rect_x,
	output logic [15:0] rect_y,
	output logic [12:0] rect_width,
	output logic [12:0] rect_height,
	output logic        key_down,
	output logic [31:0] key_symbol,
	output logic [7:0]  button_mask,
	output logic [15:0] pointer_x,
	output logic [15:0] pointer_y
);
	logic [12:0] fw_q, fh_q;
	logic f_valid, f_ready, b_valid, b_ready;
	rfb_pkg::cmd_t f_cmd, b_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= rfb_pkg::FrameWidthReset;
			fh_q <= rfb_pkg::FrameHeightReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfb_pkg::CFG_FRAME_WIDTH: fw_q <= cfg_data;
				default: fh_q <= cfg_data;
			endcase
		end
	end

	rfb_front #(.MAX_ENCODINGS(MAX_ENCODINGS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .rx_byte,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	rfb_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	rfb_back #(.MAX_FRAME_SIDE(MAX_FRAME_SIDE)) u_back (
		.clk, .arst_n, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.frame_width(fw_q), .frame_height(fh_q),
		.out_valid, .out_ready, .event_kind, .minor_version, .incremental,
		.rect_x, .rect_y, .rect_width, .rect_height, .key_down, .key_symbol,
		.button_mask, .pointer_x, .pointer_y
	);
endmodule

/* design/rfb_checker.sv */
`timescale 1ns / 1ps
`include "rfb_client_message_parser_top_macros.svh"
module rfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  event_kind,
	input logic [12:0] rect_width,
	input logic [15:0] pointer_x,
	input logic [31:0] key_symbol
);
	`RFB_ASSERT_IMPL(a_kind_range, out_valid, event_kind <= rfb_pkg::EV_ERROR)
	`RFB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(event_kind))
	`RFB_ASSERT_IMPL(a_width_cap, out_valid, rect_width <= 13'd4096)
	`RFB_ASSERT_IMPL(a_unused_zero, out_valid && event_kind == rfb_pkg::EV_UPDATE,
		pointer_x == '0 && key_symbol == '0)
endmodule

bind rfb_client_message_parser_top rfb_checker u_rfb_checker (
	.clk, .arst_n, .out_valid, .out_ready, .event_kind, .rect_width,
	.pointer_x, .key_symbol
);
